// ===== design/hdrf_pkg.sv =====
package hdrf_pkg;
  localparam int unsigned VERTICES_DEF   = 65536;
  localparam int unsigned PARTITIONS_DEF = 3;
  localparam int unsigned DEG_W          = 32;
  localparam int unsigned VID_W          = 16;
  localparam int unsigned PART_W         = 3;
  localparam int unsigned MEMB_W         = 8;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned WEIGHT_W       = 16;
  localparam int unsigned SLACK_W        = 8;
  localparam int unsigned FRAC_W         = 16;
  localparam int unsigned DIV_W          = 64;

  localparam logic [CFG_IDX_W-1:0] REG_BALANCE_WEIGHT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BALANCE_SLACK  = 1'd1;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;
  localparam logic [SLACK_W-1:0]  SLACK_RESET  = 8'd1;
endpackage

// ===== design/hdrf_stream_if.sv =====
interface hdrf_stream_if #(
  parameter int unsigned W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/hdrf_div.sv =====
// restoring divider, one quotient bit per cycle
module hdrf_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [hdrf_pkg::DIV_W-1:0]   dividend,
  input  logic [hdrf_pkg::DIV_W-1:0]   divisor,
  output logic                         done,
  output logic [hdrf_pkg::DIV_W-1:0]   quotient
);
  localparam int unsigned W = hdrf_pkg::DIV_W;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    trial;

  assign trial = {rem, quotient[W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CW'(W);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (!trial[W]) begin
          rem <= trial[W-1:0];
        end else begin
          rem <= {rem[W-2:0], quotient[W-1]};
        end
        quotient <= {quotient[W-2:0], !trial[W]};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== design/hdrf_edge_partitioner_top.sv =====
// HDRF streaming edge partitioner.
// Channel edge_in carries one word {dst_vertex, src_vertex}; channel part_out
// carries chosen_partition. Both handshake valid/ready; a word moves when both
// are high. Configuration: cfg_we, cfg_idx, cfg_data; index 0 sets
// balance_weight (Q8.8), index 1 balance_slack; other indices are ignored.
// After reset the block sweeps both vertex memories to zero, one entry per
// cycle, before edge_in.ready rises.
// One edge at a time: accept and read of both vertices, theta via the shared
// 64-bit serial divider (two divisions), then one balance division per
// partition (with the wait state S_BWAIT between partitions), then write back
// of both vertices.
// The result is held in an output register; a new edge is accepted while it
// waits, but that edge's write-back stage does not finish until the result is taken.
module hdrf_edge_partitioner_top #(
  parameter int unsigned VERTICES   = hdrf_pkg::VERTICES_DEF,
  parameter int unsigned PARTITIONS = hdrf_pkg::PARTITIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hdrf_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [hdrf_pkg::CFG_DATA_W-1:0]   cfg_data,
  hdrf_stream_if.sink                       edge_in,
  hdrf_stream_if.source                     part_out
);
  localparam int unsigned AW  = $clog2(VERTICES);
  localparam int unsigned DW  = hdrf_pkg::DEG_W;
  localparam int unsigned W64 = hdrf_pkg::DIV_W;
  localparam int unsigned PW  = hdrf_pkg::PART_W;
  localparam int unsigned MW  = hdrf_pkg::MEMB_W;
  localparam int unsigned VW  = hdrf_pkg::VID_W;
  localparam logic [DW-1:0] SAT = '1;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_RD_D  = 11'b00000000100,
    S_LAT_S = 11'b00000001000,
    S_LAT_D = 11'b00000010000,
    S_TH_S  = 11'b00000100000,
    S_TH_D  = 11'b00001000000,
    S_BAL   = 11'b00010000000,
    S_BWAIT = 11'b00100000000,
    S_WR_S  = 11'b01000000000,
    S_WR_D  = 11'b10000000000
  } state_t;

  state_t state;

  logic [hdrf_pkg::WEIGHT_W-1:0] balance_weight;
  logic [hdrf_pkg::SLACK_W-1:0]  balance_slack;

  always_ff @(posedge clk) begin
    if (rst) begin
      balance_weight <= hdrf_pkg::WEIGHT_RESET;
      balance_slack  <= hdrf_pkg::SLACK_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        hdrf_pkg::REG_BALANCE_WEIGHT: balance_weight <= cfg_data;
        hdrf_pkg::REG_BALANCE_SLACK:  balance_slack  <= cfg_data[hdrf_pkg::SLACK_W-1:0];
        default: ;
      endcase
    end
  end

  // vertex memories
  logic [DW-1:0] deg_mem  [VERTICES];
  logic [MW-1:0] memb_mem [VERTICES];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdeg, rd_deg;
  logic [MW-1:0] mem_wmemb, rd_memb;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      deg_mem[mem_waddr]  <= mem_wdeg;
      memb_mem[mem_waddr] <= mem_wmemb;
    end
    rd_deg  <= deg_mem[mem_raddr];
    rd_memb <= memb_mem[mem_raddr];
  end

  logic [AW-1:0] clr_addr;
  logic [AW-1:0] s_addr, d_addr;
  logic [DW-1:0] ds, dd;
  logic [MW-1:0] ms, md;
  logic [W64-1:0] gs, gd;
  logic [PW-1:0] pidx, chosen;
  logic [W64-1:0] best;
  logic [DW-1:0] load [PARTITIONS];
  logic [DW-1:0] maxl, minl;
  logic [W64-1:0] bdiv;
  logic out_valid;
  logic [PW-1:0] out_part;

  // divider
  logic          dv_start, dv_done;
  logic [W64-1:0] dv_num, dv_den, dv_q;
  hdrf_div u_div (
    .clk(clk), .rst(rst), .start(dv_start), .dividend(dv_num),
    .divisor(dv_den), .done(dv_done), .quotient(dv_q)
  );

  logic [W64-1:0] sum;
  assign sum = W64'(ds) + W64'(dd) + W64'(2);

  always_comb begin
    minl = SAT;
    for (int p = 0; p < PARTITIONS; p++) begin
      if (load[p] < minl) minl = load[p];
    end
  end

  logic [W64-1:0] bdiv_calc, diff_p, score;
  always_comb begin
    if (maxl < minl) bdiv_calc = W64'(balance_slack);
    else bdiv_calc = W64'(balance_slack) + W64'(maxl) - W64'(minl);
    if (bdiv_calc == '0) bdiv_calc = W64'(1);
  end

  logic [DW-1:0] load_sel;
  assign load_sel = load[pidx[$clog2(PARTITIONS)-1:0]];
  assign diff_p = (maxl > load_sel) ? W64'(maxl - load_sel) : '0;

  logic [W64-1:0] bnum;
  assign bnum = W64'(balance_weight) * diff_p << 8;

  always_comb begin
    score = dv_q;
    if (ms[pidx]) score = score + gs;
    if (md[pidx]) score = score + gd;
  end

  logic same;
  assign same = (s_addr == d_addr);
  logic [DW-1:0] ds_inc, dd_inc, ds2;
  assign ds_inc = (ds == SAT) ? ds : ds + 1'b1;
  assign ds2    = (ds_inc == SAT) ? ds_inc : ds_inc + 1'b1;
  assign dd_inc = (dd == SAT) ? dd : dd + 1'b1;

  logic [DW-1:0] newload;
  assign newload = (load[chosen[$clog2(PARTITIONS)-1:0]] == SAT) ?
                   SAT : load[chosen[$clog2(PARTITIONS)-1:0]] + 1'b1;

  assign edge_in.ready = (state == S_IDLE);
  assign part_out.valid = out_valid;
  assign part_out.data  = out_part;

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = clr_addr;
    mem_wdeg = '0;
    mem_wmemb = '0;
    mem_raddr = s_addr;
    dv_start = 1'b0;
    dv_num = '0;
    dv_den = sum;
    case (state)
      S_CLEAR: mem_we = 1'b1;
      S_IDLE:  mem_raddr = AW'(edge_in.data[VW-1:0]);
      S_RD_D:  mem_raddr = d_addr;
      S_LAT_D: begin
        dv_start = 1'b1;
        dv_num = (W64'(ds) + W64'(1)) << 16;
      end
      S_TH_S: if (dv_done) begin
        dv_start = 1'b1;
        dv_num = (W64'(dd) + W64'(1)) << 16;
      end
      S_TH_D: if (dv_done) begin
        dv_start = 1'b1;
        dv_num = bnum;
        dv_den = bdiv_calc;
      end
      S_BWAIT: begin
        dv_start = 1'b1;
        dv_num = bnum;
        dv_den = bdiv;
      end
      S_WR_S: begin
        mem_we = 1'b1;
        mem_waddr = s_addr;
        mem_wdeg = same ? ds2 : ds_inc;
        mem_wmemb = ms | MW'(1 << chosen);
      end
      S_WR_D: begin
        mem_we = !same;
        mem_waddr = d_addr;
        mem_wdeg = dd_inc;
        mem_wmemb = md | MW'(1 << chosen);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
      maxl <= '0;
      for (int p = 0; p < PARTITIONS; p++) load[p] <= '0;
    end else begin
      if (part_out.valid && part_out.ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(VERTICES - 1)) state <= S_IDLE;
        end
        S_IDLE: if (edge_in.valid) begin
          s_addr <= AW'(edge_in.data[VW-1:0]);
          d_addr <= AW'(edge_in.data[2*VW-1:VW]);
          pidx   <= '0;
          state  <= S_RD_D;
        end
        // source word arrives here, destination word in S_LAT_S
        S_RD_D: begin
          ds <= rd_deg;
          ms <= rd_memb;
          state <= S_LAT_S;
        end
        S_LAT_S: begin
          dd <= same ? ds : rd_deg;
          md <= same ? ms : rd_memb;
          state <= S_LAT_D;
        end
        S_LAT_D: state <= S_TH_S;
        S_TH_S: if (dv_done) begin
          gs <= (W64'(2) << 16) - dv_q;
          state <= S_TH_D;
        end
        S_TH_D: if (dv_done) begin
          gd <= (W64'(2) << 16) - dv_q;
          bdiv <= bdiv_calc;
          pidx <= '0;
          best <= '0;
          chosen <= '0;
          state <= S_BAL;
        end
        S_BAL: if (dv_done) begin
          if (score > best) begin
            best <= score;
            chosen <= pidx;
          end
          if (pidx == PW'(PARTITIONS - 1)) begin
            state <= S_WR_S;
          end else begin
            pidx <= pidx + 1'b1;
            state <= S_BWAIT;
          end
        end
        S_BWAIT: state <= S_BAL;
        S_WR_S: if (!out_valid) begin
          state <= S_WR_D;
          out_valid <= 1'b1;
          out_part <= chosen;
          load[chosen[$clog2(PARTITIONS)-1:0]] <= newload;
          if (newload > maxl) maxl <= newload;
        end
        S_WR_D: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  ap_one_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR_S && !out_valid) |=> out_valid)
    else $error("result not posted");
  ap_part_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_part < PW'(PARTITIONS)))
    else $error("partition out of range");
  ap_max_load: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> (load[0] <= maxl))
    else $error("max load below a load");
endmodule
